// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/mtvc_pkg.sv
// Types and constants of the moisture triggered valve controller.
`default_nettype none
package mtvc_pkg;

  localparam int unsigned TIMER_W  = 32;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_OVERRIDE = 2'd1,
    ACT_TRIGGERS = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_A     = 3'd0,
    REG_THRESHOLD_B     = 3'd1,
    REG_HOLD_TIME_MS    = 3'd2,
    REG_MAX_WATERING_MS = 3'd3,
    REG_MAX_OVERRIDE_MS = 3'd4
  } reg_idx_t;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST    = 12'd4095;
  localparam logic [TIMER_W-1:0]  HOLD_TIME_RST    = 32'd5000;
  localparam logic [TIMER_W-1:0]  MAX_WATERING_RST = 32'd60000;
  localparam logic [TIMER_W-1:0]  MAX_OVERRIDE_RST = 32'd60000;

  typedef struct packed {
    logic [1:0]          action;
    logic [DELTA_W-1:0]  elapsed_ms;
    logic [SAMPLE_W-1:0] moisture_a;
    logic [SAMPLE_W-1:0] moisture_b;
    logic                flag_value;
  } item_t;

  typedef struct packed {
    logic               valve_open;
    logic               override_on;
    logic               auto_enabled;
    logic [TIMER_W-1:0] open_time;
    logic [TIMER_W-1:0] held_time;
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold_a;
    logic [SAMPLE_W-1:0] threshold_b;
    logic [TIMER_W-1:0]  hold_time_ms;
    logic [TIMER_W-1:0]  max_watering_ms;
    logic [TIMER_W-1:0]  max_override_ms;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/moisture_triggered_valve_controller.sv
// Top level of the moisture triggered valve controller.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   action elapsed_ms moisture_a moisture_b flag_value
//   out      source     out_valid/out_stall valve_on override_active triggers_on
//                                           fault_shutoff watering_time_ms trigger_held_ms
//   cfg      sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// An accepted beat lands in the input register; the step logic then updates
// the controller state and loads the result register, and one beat is taken
// every cycle unless out_stall holds a result. The loop through the state
// registers (one 32-bit add, saturate and compare chain) sets the cycle.
// Synchronous reset empties both stages, closes the valve, disables triggers
// and restores the register defaults. While out_stall holds a result, a beat
// in the input register waits and in_stall rises; cfg_ready is always high.
`default_nettype none
module moisture_triggered_valve_controller
  import mtvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [DELTA_W-1:0]   elapsed_ms,
  input  logic [SAMPLE_W-1:0]  moisture_a,
  input  logic [SAMPLE_W-1:0]  moisture_b,
  input  logic                 flag_value,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 valve_on,
  output logic                 override_active,
  output logic                 triggers_on,
  output logic                 fault_shutoff,
  output logic [TIMER_W-1:0]   watering_time_ms,
  output logic [TIMER_W-1:0]   trigger_held_ms,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data
);

  item_t  item;
  logic   item_valid;
  state_t state;
  state_t state_next;
  cfg_t   cfg;
  logic   fault;
  logic   advance;
  logic   in_take;

  // Move the held beat on when the result register is empty or being drained.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.action     <= action;
      item.elapsed_ms <= elapsed_ms;
      item.moisture_a <= moisture_a;
      item.moisture_b <= moisture_b;
      item.flag_value <= flag_value;
    end
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_a     <= THRESHOLD_RST;
      cfg.threshold_b     <= THRESHOLD_RST;
      cfg.hold_time_ms    <= HOLD_TIME_RST;
      cfg.max_watering_ms <= MAX_WATERING_RST;
      cfg.max_override_ms <= MAX_OVERRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD_A:     cfg.threshold_a     <= cfg_data[SAMPLE_W-1:0];
        REG_THRESHOLD_B:     cfg.threshold_b     <= cfg_data[SAMPLE_W-1:0];
        REG_HOLD_TIME_MS:    cfg.hold_time_ms    <= cfg_data;
        REG_MAX_WATERING_MS: cfg.max_watering_ms <= cfg_data;
        REG_MAX_OVERRIDE_MS: cfg.max_override_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mtvc_step u_step (
    .item  (item),
    .cur   (state),
    .cfg   (cfg),
    .nxt   (state_next),
    .fault (fault)
  );

  // Controller state advances once per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      valve_on         <= state_next.valve_open;
      override_active  <= state_next.override_on;
      triggers_on      <= state_next.auto_enabled;
      fault_shutoff    <= fault;
      watering_time_ms <= state_next.open_time;
      trigger_held_ms  <= state_next.held_time;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mtvc_step.sv
// Next-state logic for one controller beat.
`default_nettype none
module mtvc_step
  import mtvc_pkg::*;
(
  input  item_t  item,
  input  state_t cur,
  input  cfg_t   cfg,
  output state_t nxt,
  output logic   fault
);

  logic [TIMER_W:0]   open_sum;
  logic [TIMER_W:0]   held_sum;
  logic [TIMER_W-1:0] open_t;
  logic [TIMER_W-1:0] held_sat;
  logic               calls;

  assign open_sum = {1'b0, cur.open_time} + {{(TIMER_W+1-DELTA_W){1'b0}}, item.elapsed_ms};
  assign held_sum = {1'b0, cur.held_time} + {{(TIMER_W+1-DELTA_W){1'b0}}, item.elapsed_ms};
  assign held_sat = held_sum[TIMER_W] ? TIMER_MAX : held_sum[TIMER_W-1:0];
  assign open_t   = !cur.valve_open ? '0 :
                    (open_sum[TIMER_W] ? TIMER_MAX : open_sum[TIMER_W-1:0]);
  assign calls    = (item.moisture_a >= cfg.threshold_a) ||
                    (item.moisture_b >= cfg.threshold_b);

  always_comb begin
    nxt   = cur;
    fault = 1'b0;
    case (action_t'(item.action))
      ACT_TICK: begin
        nxt.open_time = open_t;
        if (cur.auto_enabled && !cur.override_on) begin
          nxt.held_time = calls ? held_sat : '0;
          if (nxt.held_time >= cfg.hold_time_ms && open_t < cfg.max_watering_ms) begin
            nxt.valve_open = 1'b1;
          end else begin
            if (open_t >= cfg.max_watering_ms) begin
              nxt.auto_enabled = 1'b0;
              fault            = 1'b1;
            end
            nxt.valve_open = 1'b0;
          end
        end else begin
          nxt.held_time = '0;
        end
        // end the override once it has run its maximum
        if (cur.override_on && nxt.valve_open && open_t >= cfg.max_override_ms) begin
          nxt.held_time   = '0;
          nxt.override_on = 1'b0;
          nxt.valve_open  = 1'b0;
        end
      end
      ACT_OVERRIDE: begin
        nxt.held_time   = '0;
        nxt.override_on = item.flag_value;
        nxt.valve_open  = item.flag_value;
      end
      ACT_TRIGGERS: begin
        nxt.auto_enabled = item.flag_value;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/mtvc_checker.sv
// Port-level checks for the valve controller, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module mtvc_checker
  import mtvc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 valve_on,
  input logic                 override_active,
  input logic                 triggers_on,
  input logic                 fault_shutoff,
  input logic [TIMER_W-1:0]   trigger_held_ms
);

  // hold a stalled result beat
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid)
  // drop every result across reset
  `ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid)
  // a fault beat shows triggers off and the valve shut
  `ASSERT_CLK(a_fault_shut, out_valid && fault_shutoff |-> !triggers_on && !valve_on)
  // an override keeps the valve open and the hold timer clear
  `ASSERT_CLK(a_override, out_valid && override_active |-> valve_on && trigger_held_ms == '0)

endmodule

bind moisture_triggered_valve_controller mtvc_checker u_mtvc_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the moisture triggered valve controller.
module tb_top;
  import mtvc_pkg::*;

  localparam int unsigned HALF_PERIOD     = 6;
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int unsigned SOAK_TICKS      = 120;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned BEATS_PER_PHASE = 135;
  localparam int unsigned BURST_HOLD      = 150;
  localparam int unsigned BURST_BEATS     = 40;
  localparam int unsigned IDLE_PCT        = 35;
  localparam int unsigned PRINT_CAP       = 100;

  // Action code the block treats as a no-op, and a register index it ignores.
  localparam logic [1:0]           ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [DELTA_W-1:0]  DELTA_MAX  = '1;
  localparam logic [TIMER_W-1:0]  SOAK_WATER_LIMIT = 32'd5_000_000;

  // One result beat, in port order.
  typedef struct packed {
    logic               valve_on;
    logic               override_active;
    logic               triggers_on;
    logic               fault_shutoff;
    logic [TIMER_W-1:0] watering_time_ms;
    logic [TIMER_W-1:0] trigger_held_ms;
  } status_t;

  // Shadow of the controller: tracks valve, override and trigger state plus
  // both timers, and queues the status each accepted beat must produce.
  class valve_tracker;
    cfg_t               regs;
    logic               valve;
    logic               manual;
    logic               armed;
    logic [TIMER_W-1:0] open_ms;
    logic [TIMER_W-1:0] held_ms;
    status_t            pending_status[$];
    int unsigned        mismatches;
    int unsigned        printed;
    int unsigned        beats;
    int unsigned        results;
    int unsigned        faults;
    int unsigned        override_timeouts;
    int unsigned        saturations;

    function new();
      regs = '{THRESHOLD_RST, THRESHOLD_RST, HOLD_TIME_RST, MAX_WATERING_RST,
               MAX_OVERRIDE_RST};
      valve = 1'b0;
      manual = 1'b0;
      armed = 1'b0;
      open_ms = '0;
      held_ms = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] data);
      case (idx)
        REG_THRESHOLD_A:     regs.threshold_a = data[SAMPLE_W-1:0];
        REG_THRESHOLD_B:     regs.threshold_b = data[SAMPLE_W-1:0];
        REG_HOLD_TIME_MS:    regs.hold_time_ms = data;
        REG_MAX_WATERING_MS: regs.max_watering_ms = data;
        REG_MAX_OVERRIDE_MS: regs.max_override_ms = data;
        default: ;
      endcase
    endfunction

    // Add elapsed time to a timer, pinning it at the top on overflow.
    function logic [TIMER_W-1:0] timer_add(logic [TIMER_W-1:0] acc,
                                           logic [DELTA_W-1:0] step);
      logic [TIMER_W:0] sum;
      sum = {1'b0, acc} + {{(TIMER_W+1-DELTA_W){1'b0}}, step};
      if (sum[TIMER_W]) begin
        saturations++;
        return TIMER_MAX;
      end
      return sum[TIMER_W-1:0];
    endfunction

    function void note_beat(item_t it);
      status_t st;
      logic    fault;
      fault = 1'b0;
      beats++;
      case (it.action)
        ACT_TICK: begin
          open_ms = valve ? timer_add(open_ms, it.elapsed_ms) : '0;
          if (armed && !manual) begin
            if (it.moisture_a >= regs.threshold_a || it.moisture_b >= regs.threshold_b)
              held_ms = timer_add(held_ms, it.elapsed_ms);
            else
              held_ms = '0;
            if (held_ms >= regs.hold_time_ms && open_ms < regs.max_watering_ms) begin
              valve = 1'b1;
            end else begin
              if (open_ms >= regs.max_watering_ms) begin
                armed = 1'b0;
                fault = 1'b1;
                faults++;
              end
              valve = 1'b0;
            end
          end else begin
            held_ms = '0;
          end
          // override runs out only while it holds the valve open
          if (manual && valve && open_ms >= regs.max_override_ms) begin
            held_ms = '0;
            manual = 1'b0;
            valve = 1'b0;
            override_timeouts++;
          end
        end
        ACT_OVERRIDE: begin
          held_ms = '0;
          manual = it.flag_value;
          valve = it.flag_value;
        end
        ACT_TRIGGERS: armed = it.flag_value;
        default: ;
      endcase
      st = '{valve, manual, armed, fault, open_ms, held_ms};
      pending_status.push_back(st);
    endfunction

    task flag_error(string what);
      mismatches++;
      if (printed < PRINT_CAP) begin
        printed++;
        $display("[%0t] mismatch: %s", $time, what);
      end
    endtask

    task compare_field(string name, logic [TIMER_W-1:0] got, logic [TIMER_W-1:0] want);
      if (got !== want)
        flag_error($sformatf("result %0d %s = %0h, want %0h", results, name, got, want));
    endtask

    task check_status(status_t got);
      status_t want;
      if (pending_status.size() == 0) begin
        flag_error($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = pending_status.pop_front();
      results++;
      compare_field("valve_on", TIMER_W'(got.valve_on), TIMER_W'(want.valve_on));
      compare_field("override_active", TIMER_W'(got.override_active),
                    TIMER_W'(want.override_active));
      compare_field("triggers_on", TIMER_W'(got.triggers_on), TIMER_W'(want.triggers_on));
      compare_field("fault_shutoff", TIMER_W'(got.fault_shutoff),
                    TIMER_W'(want.fault_shutoff));
      compare_field("watering_time_ms", got.watering_time_ms, want.watering_time_ms);
      compare_field("trigger_held_ms", got.trigger_held_ms, want.trigger_held_ms);
    endtask
  endclass

  // Block ports; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = '0;
  logic [DELTA_W-1:0]   elapsed_ms = '0;
  logic [SAMPLE_W-1:0]  moisture_a = '0;
  logic [SAMPLE_W-1:0]  moisture_b = '0;
  logic                 flag_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 valve_on;
  logic                 override_active;
  logic                 triggers_on;
  logic                 fault_shutoff;
  logic [TIMER_W-1:0]   watering_time_ms;
  logic [TIMER_W-1:0]   trigger_held_ms;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIMER_W-1:0]   cfg_data = '0;

  // Traffic shaping shared by the two sides.
  bit          steady_send = 1'b0;  // sender offers back-to-back beats
  bit          steady_take = 1'b0;  // receiver never stalls
  int unsigned stall_burst = 0;     // request for a long receiver hold-off
  cfg_t        settings = '{THRESHOLD_RST, THRESHOLD_RST, HOLD_TIME_RST,
                            MAX_WATERING_RST, MAX_OVERRIDE_RST};
  int unsigned setting_count = 1;

  valve_tracker tracker = new();

  moisture_triggered_valve_controller dut (.*);

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: check each accepted beat against the oldest expectation, then
  // pick the stall for the next cycle. A burst request holds stall high for the
  // length it asks for, so the input side backs up.
  initial begin : take_results
    int unsigned hold_left;
    status_t     got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{valve_on, override_active, triggers_on, fault_shutoff,
                watering_time_ms, trigger_held_ms};
        tracker.check_status(got);
      end
      if (stall_burst != 0) begin
        hold_left = stall_burst;
        stall_burst = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady_take) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic item_t beat(logic [1:0] act, logic [DELTA_W-1:0] ms,
                                 logic [SAMPLE_W-1:0] level_a,
                                 logic [SAMPLE_W-1:0] level_b, logic flag);
    item_t it;
    it = '{act, ms, level_a, level_b, flag};
    return it;
  endfunction

  // Sample either anywhere in range or within four counts of a threshold.
  function automatic logic [SAMPLE_W-1:0] near_level(logic [SAMPLE_W-1:0] level);
    int v;
    if ($urandom_range(1)) return SAMPLE_W'($urandom);
    v = int'(level) + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(3))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIMER_W-1:0] pick_limit(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 25) return TIMER_MAX;
    return $urandom_range(span);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.threshold_a = pick_level();
    s.threshold_b = pick_level();
    s.hold_time_ms = pick_limit(20000);
    s.max_watering_ms = pick_limit(150000);
    s.max_override_ms = pick_limit(100000);
    return s;
  endfunction

  // Mostly ticks; enabling triggers is favored so watering cycles get going.
  function automatic item_t random_beat();
    item_t       it;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 68) it.action = ACT_TICK;
    else if (roll < 80) it.action = ACT_OVERRIDE;
    else if (roll < 95) it.action = ACT_TRIGGERS;
    else it.action = ACT_UNUSED;
    roll = $urandom_range(99);
    if (roll < 10) it.elapsed_ms = '0;
    else if (roll < 20) it.elapsed_ms = DELTA_MAX;
    else if (roll < 65) it.elapsed_ms = DELTA_W'($urandom_range(3000));
    else it.elapsed_ms = DELTA_W'($urandom);
    it.moisture_a = near_level(settings.threshold_a);
    it.moisture_b = near_level(settings.threshold_b);
    if (it.action == ACT_TRIGGERS) it.flag_value = ($urandom_range(3) != 0);
    else it.flag_value = 1'($urandom_range(1));
    return it;
  endfunction

  // Offer one beat, after a random gap unless steady, and hold it until taken.
  task automatic send_beat(item_t it);
    if (!steady_send)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid   <= 1'b1;
    action     <= it.action;
    elapsed_ms <= it.elapsed_ms;
    moisture_a <= it.moisture_a;
    moisture_b <= it.moisture_b;
    flag_value <= it.flag_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_beat(it);
  endtask

  // Drop valid and hold until every expected status has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // Threshold writes carry junk above bit 11, which the block must drop.
  task automatic apply_settings(cfg_t s);
    logic [TIMER_W-1:0] junk_a;
    logic [TIMER_W-1:0] junk_b;
    junk_a = $urandom;
    junk_b = $urandom;
    write_reg(REG_THRESHOLD_A, {junk_a[TIMER_W-1:SAMPLE_W], s.threshold_a});
    write_reg(REG_THRESHOLD_B, {junk_b[TIMER_W-1:SAMPLE_W], s.threshold_b});
    write_reg(REG_HOLD_TIME_MS, s.hold_time_ms);
    write_reg(REG_MAX_WATERING_MS, s.max_watering_ms);
    write_reg(REG_MAX_OVERRIDE_MS, s.max_override_ms);
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    settings = s;
    setting_count++;
  endtask

  initial begin : drive_beats
    cfg_t s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values: disabled ticks, no-op action, trigger on each
    // sensor, fault at max watering, override run-out at its limit.
    send_beat(beat(ACT_TICK, DELTA_MAX, '0, '0, 1'b0));
    send_beat(beat(ACT_UNUSED, 16'h5A5A, 12'hA5A, 12'h5A5, 1'b1));
    send_beat(beat(ACT_TRIGGERS, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_TICK, 16'd1000, SAMPLE_MAX - 1'b1, SAMPLE_MAX - 1'b1, 1'b0));
    send_beat(beat(ACT_TICK, DELTA_MAX, SAMPLE_MAX, '0, 1'b0));
    send_beat(beat(ACT_TICK, '0, '0, SAMPLE_MAX, 1'b0));
    send_beat(beat(ACT_TICK, DELTA_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    send_beat(beat(ACT_TRIGGERS, DELTA_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_TICK, 16'd30000, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_beat(beat(ACT_TICK, 16'd30000, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b0));
    send_beat(beat(ACT_TRIGGERS, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_TICK, 16'd100, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b0));
    wait_drained();

    // All registers zero: a zero watering limit faults on the first armed
    // tick, and a zero override limit ends an override on its first tick.
    s = '{'0, '0, '0, '0, '0};
    apply_settings(s);
    send_beat(beat(ACT_TRIGGERS, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_TICK, 16'd100, '0, '0, 1'b0));
    send_beat(beat(ACT_TRIGGERS, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_TICK, 16'd5, SAMPLE_MAX, '0, 1'b0));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_UNUSED, '0, '0, '0, 1'b0));
    send_beat(beat(ACT_OVERRIDE, '0, '0, '0, 1'b0));
    wait_drained();

    // Stretch with no idling on either side: open the valve with the override
    // limit at the top and tick at full step back to back until the watering
    // limit trips, then keep ticking with triggers off.
    s = '{'0, '0, '0, SOAK_WATER_LIMIT, TIMER_MAX};
    apply_settings(s);
    steady_send = 1'b1;
    steady_take = 1'b1;
    send_beat(beat(ACT_TRIGGERS, '0, '0, '0, 1'b1));
    send_beat(beat(ACT_TICK, DELTA_MAX, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   1'($urandom)));
    send_beat(beat(ACT_TICK, 16'd1, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   1'($urandom)));
    repeat (SOAK_TICKS)
      send_beat(beat(ACT_TICK, DELTA_MAX, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'($urandom)));
    steady_send = 1'b0;
    steady_take = 1'b0;
    wait_drained();

    // Random phases, one register setting each. In the second, hold the
    // receiver off while beats keep coming so the block backs up.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(random_settings());
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (p == 1 && n == BEATS_PER_PHASE / 2) begin
          stall_burst = BURST_HOLD;
          steady_send = 1'b1;
        end
        if (p == 1 && n == BEATS_PER_PHASE / 2 + BURST_BEATS) steady_send = 1'b0;
        send_beat(random_beat());
      end
      wait_drained();
    end

    $display("Covered %0d beats under %0d register settings, %0d results checked.",
             tracker.beats, setting_count, tracker.results);
    $display("Saw %0d fault shutoffs, %0d override run-outs, %0d timer saturations.",
             tracker.faults, tracker.override_timeouts, tracker.saturations);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mtvc_pkg.sv
rtl/mtvc_step.sv
rtl/moisture_triggered_valve_controller.sv
rtl/mtvc_checker.sv
test/tb_top.sv
